// ===== src/tjli_pkg.sv =====
// Package for the three-joint linear interpolator.
// Holds widths, angle constants, the sequencer state type and the divider request
// and response structs. No dependencies.
`default_nettype none

package tjli_pkg;

	localparam int AngleW    = 14;
	localparam int TargetW   = 16;
	localparam int StepW     = 6;
	localparam int HoldW     = 16;
	localparam int AccFracW  = 8;
	localparam int MagW      = AngleW + AccFracW;   // dividend magnitude width
	localparam int IncW      = MagW + 1;            // signed increment width
	localparam int DivCntW   = $clog2(MagW + 1);
	localparam int JointN    = 3;
	localparam int JointIdxW = 2;
	localparam int InDataW   = 72;
	localparam int OutDataW  = 64;

	localparam logic [StepW-1:0]   MaxSteps  = StepW'(63);
	localparam logic [AngleW-1:0]  AngleHome = AngleW'(90 << 6);
	localparam logic [TargetW-1:0] AngleMax  = TargetW'(180 << 6);
	localparam logic [JointIdxW-1:0] LastJoint = JointIdxW'(JointN - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_EMIT,
		ST_LAST
	} tjli_state_t;

	typedef struct packed {
		logic              start;
		logic              neg;
		logic [MagW-1:0]   mag;
		logic [StepW-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                   done;
		logic signed [IncW-1:0] quot;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== src/tjli_div.sv =====
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Used in turn for all three joint increments. Depends on tjli_pkg.
`default_nettype none

module tjli_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tjli_pkg::div_req_t req,
	output tjli_pkg::div_rsp_t      rsp
);

	logic [tjli_pkg::MagW-1:0]    work_q;
	logic [tjli_pkg::StepW-1:0]   rem_q;
	logic [tjli_pkg::StepW-1:0]   div_q;
	logic [tjli_pkg::DivCntW-1:0] cnt_q;
	logic                         neg_q;
	logic                         run_q;
	logic                         done_q;
	logic [tjli_pkg::StepW:0]     trial;
	logic                         ge;
	logic [tjli_pkg::StepW:0]     diff;

	// Bring down the next dividend bit and try to subtract the divisor.
	always_comb begin
		trial = {rem_q, work_q[tjli_pkg::MagW-1]};
		ge    = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == tjli_pkg::DivCntW'(1));
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= tjli_pkg::DivCntW'(tjli_pkg::MagW);
			end else if (run_q) begin
				cnt_q <= cnt_q - tjli_pkg::DivCntW'(1);
				if (cnt_q == tjli_pkg::DivCntW'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= req.mag;
			rem_q  <= '0;
			div_q  <= req.divisor;
			neg_q  <= req.neg;
		end else if (run_q) begin
			work_q <= {work_q[tjli_pkg::MagW-2:0], ge};
			rem_q  <= ge ? diff[tjli_pkg::StepW-1:0] : trial[tjli_pkg::StepW-1:0];
		end
	end

	always_comb begin
		rsp.done = done_q;
		rsp.quot = neg_q ? -$signed({1'b0, work_q}) : $signed({1'b0, work_q});
	end

endmodule

`default_nettype wire

// ===== src/three_joint_linear_interpolator.sv =====
// Three-joint linear interpolator, top level.
// Depends on tjli_pkg and tjli_div.
//
// Usage: the slave stream takes one command word: three joint targets, a step
// count and a hold time. The master stream gives step_count intermediate
// positions carrying the hold time, then the exact target with tlast set and
// a hold of zero. A command with any target outside 0 to 180 degrees gives no
// words, leaves the stored position unchanged and frees the input at once.
//
// Timing: with a nonzero step count, the single shared divider computes the
// three joint increments one after another, each joint passing through the
// DIV_START and DIV_WAIT states, before the first word is registered. Then one
// word leaves per cycle while the receiver takes them. A direct move skips the
// divider. s_tready is high only between commands; the next command may be
// taken while the final word still waits in the output register.
//
// Reset puts every joint at ninety degrees and empties the output register.
// When the receiver stalls, the output word holds and no further word is emitted.
`default_nettype none

module three_joint_linear_interpolator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// target_angle_1, target_angle_2, target_angle_3, step_count, delay_ms, zero pad
	input  wire logic [tjli_pkg::InDataW-1:0]  s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// joint_angle_1, joint_angle_2, joint_angle_3, hold_ms, zero pad
	output logic [tjli_pkg::OutDataW-1:0]      m_tdata,
	output logic                               m_tlast
);

	tjli_pkg::tjli_state_t state_q, state_n;

	logic [tjli_pkg::AngleW-1:0]       cur_q  [tjli_pkg::JointN];
	logic [tjli_pkg::AngleW-1:0]       tgt_q  [tjli_pkg::JointN];
	logic [tjli_pkg::MagW-1:0]         acc_q  [tjli_pkg::JointN];
	logic signed [tjli_pkg::IncW-1:0]  inc_q  [tjli_pkg::JointN];
	logic [tjli_pkg::MagW-1:0]         acc_n  [tjli_pkg::JointN];
	logic [tjli_pkg::HoldW-1:0]        hold_q;
	logic [tjli_pkg::StepW-1:0]        steps_q;
	logic [tjli_pkg::JointIdxW-1:0]    jidx_q;
	logic                              m_tvalid_q;
	logic [tjli_pkg::OutDataW-1:0]     m_tdata_q;
	logic                              m_tlast_q;

	logic signed [tjli_pkg::TargetW-1:0] in_tgt [tjli_pkg::JointN];
	logic [tjli_pkg::StepW-1:0]          in_steps;
	logic                                in_ok;
	logic                                out_free;
	logic                                accept;
	logic                                div_start;
	logic                                load_inc;
	logic                                load_step;
	logic                                load_last;
	logic signed [tjli_pkg::AngleW:0]    jdiff;
	logic [tjli_pkg::AngleW-1:0]         jmag;

	tjli_pkg::div_req_t div_req;
	tjli_pkg::div_rsp_t div_rsp;

	always_comb begin
		for (int j = 0; j < tjli_pkg::JointN; j++) begin
			in_tgt[j] = s_tdata[j*tjli_pkg::TargetW +: tjli_pkg::TargetW];
		end
		in_steps = s_tdata[48 +: tjli_pkg::StepW];
		if (in_steps > tjli_pkg::MaxSteps) begin
			in_steps = tjli_pkg::MaxSteps;
		end
		in_ok = 1'b1;
		for (int j = 0; j < tjli_pkg::JointN; j++) begin
			if (in_tgt[j] < 0 || in_tgt[j] > $signed(tjli_pkg::AngleMax)) begin
				in_ok = 1'b0;
			end
		end
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			tjli_pkg::ST_IDLE: begin
				if (s_tvalid && in_ok) begin
					state_n = (in_steps == '0) ? tjli_pkg::ST_LAST : tjli_pkg::ST_DIV_START;
				end
			end
			tjli_pkg::ST_DIV_START: begin
				state_n = tjli_pkg::ST_DIV_WAIT;
			end
			tjli_pkg::ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					state_n = (jidx_q == tjli_pkg::LastJoint) ? tjli_pkg::ST_EMIT
						: tjli_pkg::ST_DIV_START;
				end
			end
			tjli_pkg::ST_EMIT: begin
				if (out_free && steps_q == tjli_pkg::StepW'(1)) begin
					state_n = tjli_pkg::ST_LAST;
				end
			end
			tjli_pkg::ST_LAST: begin
				if (out_free) begin
					state_n = tjli_pkg::ST_IDLE;
				end
			end
			default: state_n = tjli_pkg::ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		load_inc  = 1'b0;
		load_step = 1'b0;
		load_last = 1'b0;
		unique case (state_q)
			tjli_pkg::ST_IDLE:      s_tready  = 1'b1;
			tjli_pkg::ST_DIV_START: div_start = 1'b1;
			tjli_pkg::ST_DIV_WAIT:  load_inc  = div_rsp.done;
			tjli_pkg::ST_EMIT:      load_step = out_free;
			tjli_pkg::ST_LAST:      load_last = out_free;
			default: ;
		endcase
	end

	// Distance of the joint being divided, split into sign and magnitude.
	always_comb begin
		jdiff = $signed({1'b0, tgt_q[jidx_q]}) - $signed({1'b0, cur_q[jidx_q]});
		jmag  = jdiff[tjli_pkg::AngleW] ? tjli_pkg::AngleW'(-jdiff)
			: jdiff[tjli_pkg::AngleW-1:0];
		div_req.start   = div_start;
		div_req.neg     = jdiff[tjli_pkg::AngleW];
		div_req.mag     = {jmag, {tjli_pkg::AccFracW{1'b0}}};
		div_req.divisor = steps_q;
	end

	tjli_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// The accumulator stays between the start and the target, so it is never negative.
	always_comb begin
		for (int j = 0; j < tjli_pkg::JointN; j++) begin
			acc_n[j] = tjli_pkg::MagW'($signed({1'b0, acc_q[j]}) + inc_q[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tjli_pkg::ST_IDLE;
			m_tvalid_q <= 1'b0;
			jidx_q     <= '0;
			for (int j = 0; j < tjli_pkg::JointN; j++) begin
				cur_q[j] <= tjli_pkg::AngleHome;
			end
		end else begin
			state_q <= state_n;
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (load_step || load_last) begin
				m_tvalid_q <= 1'b1;
			end
			if (accept) begin
				jidx_q <= '0;
			end else if (load_inc) begin
				jidx_q <= jidx_q + tjli_pkg::JointIdxW'(1);
			end
			if (load_last) begin
				cur_q <= tgt_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int j = 0; j < tjli_pkg::JointN; j++) begin
				tgt_q[j] <= tjli_pkg::AngleW'(in_tgt[j]);
			end
			steps_q <= in_steps;
			hold_q  <= s_tdata[54 +: tjli_pkg::HoldW];
		end
		if (load_inc) begin
			inc_q[jidx_q] <= div_rsp.quot;
			acc_q[jidx_q] <= {cur_q[jidx_q], {tjli_pkg::AccFracW{1'b0}}};
		end
		if (load_step) begin
			steps_q   <= steps_q - tjli_pkg::StepW'(1);
			acc_q     <= acc_n;
			m_tdata_q <= {6'b0, hold_q,
				acc_n[2][tjli_pkg::MagW-1 -: tjli_pkg::AngleW],
				acc_n[1][tjli_pkg::MagW-1 -: tjli_pkg::AngleW],
				acc_n[0][tjli_pkg::MagW-1 -: tjli_pkg::AngleW]};
			m_tlast_q <= 1'b0;
		end
		if (load_last) begin
			m_tdata_q <= {6'b0, {tjli_pkg::HoldW{1'b0}}, tgt_q[2], tgt_q[1], tgt_q[0]};
			m_tlast_q <= 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

`default_nettype wire

// ===== src/tjli_checker.sv =====
// Port-level checks for the three-joint linear interpolator, bound to the top level.
// Depends on tjli_pkg.
`default_nettype none

module tjli_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic [tjli_pkg::InDataW-1:0]  s_tdata,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [tjli_pkg::OutDataW-1:0] m_tdata,
	input wire logic                          m_tlast
);

	// An intermediate word means a run is in progress, so no command may be taken.
	a_busy_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("command input ready during a run");

	// The final word of a run carries a zero hold time.
	a_last_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[57:42] == 16'd0)
		else $error("final word has nonzero hold");

	// Every emitted joint position lies within 0 to 180 degrees.
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[13:0] <= 14'd11520 && m_tdata[27:14] <= 14'd11520
			&& m_tdata[41:28] <= 14'd11520)
		else $error("joint position out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

endmodule

bind three_joint_linear_interpolator tjli_checker u_tjli_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire
